[hdl/tpc_pkg.sv]
// Shared types and constants for the triangle plane clipper.
// No dependencies; every other file in hdl/ imports this package.
package tpc_pkg;

   localparam int POS_W   = 32;              // Q16.16 positions
   localparam int NORM_W  = 16;              // Q2.14 normals
   localparam int ID_W    = 20;
   localparam int COLOR_W = 24;
   localparam int TRI_W   = 16;
   localparam int T_FRAC  = 16;              // fraction bits of the edge parameter
   localparam int N_FRAC  = NORM_W - 2;      // fraction bits of a unit normal

   localparam int DIST_W  = POS_W + NORM_W + 2;   // signed plane distance
   localparam int DIV_W   = DIST_W;               // unsigned divider operands
   localparam int QUOT_W  = T_FRAC + 1;
   localparam int STEP_W  = $clog2(T_FRAC + 1);
   localparam int MUL_A_W = POS_W + 1;
   localparam int MUL_B_W = T_FRAC + 2;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int LEN2_W  = 2 * NORM_W;
   localparam int LEN_W   = NORM_W;

   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;
   localparam logic [NORM_W-1:0] PNZ_RESET = NORM_W'(16384);

   typedef enum logic [1:0] {
      CSR_PNX  = 2'd0,
      CSR_PNY  = 2'd1,
      CSR_PNZ  = 2'd2,
      CSR_POFF = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  vertex_x;
      logic signed [POS_W-1:0]  vertex_y;
      logic signed [POS_W-1:0]  vertex_z;
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic [ID_W-1:0]          vertex_id;
      logic [COLOR_W-1:0]       tri_color;
      logic [TRI_W-1:0]         tri_index;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  out_x;
      logic signed [POS_W-1:0]  out_y;
      logic signed [POS_W-1:0]  out_z;
      logic signed [NORM_W-1:0] out_nx;
      logic signed [NORM_W-1:0] out_ny;
      logic signed [NORM_W-1:0] out_nz;
      logic [ID_W-1:0]          out_vertex_id;
      logic                     is_new_vertex;
      logic [COLOR_W-1:0]       out_color;
      logic [TRI_W-1:0]         out_tri_index;
      logic                     tri_end;
      logic                     run_last;
   } rsp_type;

   typedef struct packed {
      logic [2:0][POS_W-1:0]  pos;
      logic [2:0][NORM_W-1:0] norm;
      logic [ID_W-1:0]        id;
   } vertex_type;

   typedef struct packed {
      vertex_type [2:0]   vtx;
      logic [COLOR_W-1:0] color;
      logic [TRI_W-1:0]   tri_index;
   } tri_type;

   typedef struct packed {
      logic [2:0][NORM_W-1:0] norm;
      logic [POS_W-1:0]       offset;
   } plane_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  num;
      logic [DIV_W-1:0]  den;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DIST, S_DWAIT, S_CLASS, S_TSTART, S_TWAIT, S_LERP, S_LWAIT,
      S_LEN, S_LENWAIT, S_SQRT, S_NSTART, S_NWAIT, S_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      MODE_ALL, MODE_ONE, MODE_TWO
   } mode_type;

   typedef enum logic [2:0] {
      SRC_V0, SRC_V1, SRC_V2, SRC_CUT0, SRC_CUT1
   } src_type;

   typedef enum logic [1:0] {
      WB_DIST, WB_LERP, WB_LEN
   } wb_kind_type;

   typedef struct packed {
      logic        valid;
      wb_kind_type kind;
      logic [1:0]  v;
      logic [2:0]  c;
   } wb_type;

   typedef struct packed {
      src_type src;
      logic    tri_end;
      logic    last;
   } emit_type;

endpackage

[hdl/tpc_front.sv]
// Front end: collects three vertex transactions into one triangle record.
// Depends on tpc_pkg.
module tpc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tpc_pkg::req_type req_payload,
   output logic             push_valid,
   input  logic             push_ready,
   output tpc_pkg::tri_type push_data
);
   import tpc_pkg::*;

   logic [1:0]         count_ff, count_in;
   vertex_type [1:0]   held_ff, held_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [TRI_W-1:0]   index_ff, index_in;
   vertex_type         cur;
   logic               accept;

   assign cur.pos  = {req_payload.vertex_z, req_payload.vertex_y, req_payload.vertex_x};
   assign cur.norm = {req_payload.normal_z, req_payload.normal_y, req_payload.normal_x};
   assign cur.id   = req_payload.vertex_id;

   assign req_ready  = (count_ff != 2'd2) || push_ready;
   assign push_valid = req_valid && (count_ff == 2'd2);
   assign accept     = req_valid && req_ready;

   always_comb begin
      push_data.vtx       = {cur, held_ff[1], held_ff[0]};
      push_data.color     = color_ff;
      push_data.tri_index = index_ff;
   end

   always_comb begin
      count_in = count_ff;
      held_in  = held_ff;
      color_in = color_ff;
      index_in = index_ff;
      if (accept) begin
         if (count_ff == 2'd2) begin
            count_in = 2'd0;
         end else begin
            held_in[count_ff[0]] = cur;
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               color_in = req_payload.tri_color;
               index_in = req_payload.tri_index;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff  <= held_in;
      color_ff <= color_in;
      index_ff <= index_in;
   end

endmodule

[hdl/tpc_queue.sv]
// Two-entry triangle queue between front end and clip engine.
// Depends on tpc_pkg.
module tpc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tpc_pkg::tri_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output tpc_pkg::tri_type pop_data
);
   import tpc_pkg::*;

   tri_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/tpc_div.sv]
// Bit-serial fraction divider: floor(num * 2^steps / den) for num <= den.
// Depends on tpc_pkg.
module tpc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tpc_pkg::div_req_type div_req,
   output tpc_pkg::div_rsp_type div_rsp
);
   import tpc_pkg::*;

   logic [DIV_W:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]  den_ff, den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              first_ff, first_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    cand;
   logic              ge;

   // first step compares the numerator as is, later steps shift one bit in
   assign cand = first_ff ? rem_ff : {rem_ff[DIV_W-1:0], 1'b0};
   assign ge   = cand >= {1'b0, den_ff};

   always_comb begin
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      first_in = first_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in   = {1'b0, div_req.num};
         den_in   = div_req.den;
         quot_in  = '0;
         step_in  = div_req.steps;
         busy_in  = 1'b1;
         first_in = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? (cand - {1'b0, den_ff}) : cand;
         quot_in  = {quot_ff[QUOT_W-2:0], ge};
         first_in = 1'b0;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
      first_ff <= first_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

[hdl/tpc_back.sv]
// Clip engine: distances, classification, edge cuts, normalization, emission.
// Depends on tpc_pkg; uses the shared tpc_div unit through div_req/div_rsp.
module tpc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tpc_pkg::plane_type   plane,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  tpc_pkg::tri_type     pop_data,
   output tpc_pkg::div_req_type div_req,
   input  tpc_pkg::div_rsp_type div_rsp,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tpc_pkg::rsp_type     rsp_payload
);
   import tpc_pkg::*;

   localparam logic [LEN2_W-1:0] SQ_BIT0 = LEN2_W'(1) << (LEN2_W - 2);

   back_state_type state_ff, state_in;

   vertex_type [2:0]             vtx_ff, vtx_in;
   logic signed [DIST_W-1:0]     dist_ff [3];
   logic signed [DIST_W-1:0]     dist_in [3];
   logic [COLOR_W-1:0]           color_ff, color_in;
   logic [TRI_W-1:0]             index_ff, index_in;
   vertex_type [1:0]             cut_ff, cut_in;
   mode_type                     mode_ff, mode_in;
   logic [1:0]                   op_v_ff, op_v_in;
   logic [2:0]                   op_c_ff, op_c_in;
   logic                         edge_sel_ff, edge_sel_in;
   logic [QUOT_W-1:0]            t_ff, t_in;
   logic [LEN2_W-1:0]            len2_ff, len2_in;
   logic [LEN2_W-1:0]            sq_v_ff, sq_v_in;
   logic [LEN2_W-1:0]            sq_r_ff, sq_r_in;
   logic [LEN2_W-1:0]            sq_bit_ff, sq_bit_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [2:0]                   emit_ff, emit_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   wb_type                       wb_ff, wb_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic [2:0]                   in_mask;
   logic [1:0]                   n_inside;
   logic [1:0]                   lead;
   logic                         out_load;
   emit_type                     item;
   logic [1:0]                   far_idx;
   logic [DIV_W-1:0]             t_num, t_den;
   logic signed [DIST_W-1:0]     off_term;
   logic signed [PROD_W-1:0]     lerp_base, lerp_sum;
   logic [LEN2_W:0]              sq_sum;
   logic                         sq_ge;
   logic [LEN_W-1:0]             nq;
   logic [NORM_W-1:0]            ncur;
   vertex_type                   src_v;
   logic                         last_op;

   function automatic logic [DIV_W-1:0] dist_mag(input logic signed [DIST_W-1:0] d);
      return d[DIST_W-1] ? DIV_W'(-d) : DIV_W'(d);
   endfunction

   function automatic logic [NORM_W:0] norm_mag(input logic [NORM_W-1:0] n);
      logic [NORM_W:0] e;
      e = {n[NORM_W-1], n};
      return n[NORM_W-1] ? (~e + 1'b1) : e;
   endfunction

   function automatic logic [1:0] rot_idx(input logic [1:0] ld, input logic [1:0] i);
      logic [2:0] s;
      s = {1'b0, ld} + {1'b0, i};
      return (s >= 3'd3) ? 2'(s - 3'd3) : 2'(s);
   endfunction

   function automatic emit_type emit_item(input mode_type m, input logic [2:0] k);
      emit_type e;
      e = '{src: SRC_V0, tri_end: 1'b0, last: 1'b0};
      unique case (m)
         MODE_ALL: begin
            unique case (k)
               3'd0:    e.src = SRC_V0;
               3'd1:    e.src = SRC_V1;
               default: e = '{src: SRC_V2, tri_end: 1'b1, last: 1'b1};
            endcase
         end
         MODE_ONE: begin
            unique case (k)
               3'd0:    e.src = SRC_V0;
               3'd1:    e.src = SRC_CUT0;
               default: e = '{src: SRC_CUT1, tri_end: 1'b1, last: 1'b1};
            endcase
         end
         default: begin
            unique case (k)
               3'd0:    e.src = SRC_CUT0;
               3'd1:    e.src = SRC_V1;
               3'd2:    e = '{src: SRC_V2, tri_end: 1'b1, last: 1'b0};
               3'd3:    e.src = SRC_V2;
               3'd4:    e.src = SRC_CUT1;
               default: e = '{src: SRC_CUT0, tri_end: 1'b1, last: 1'b1};
            endcase
         end
      endcase
      return e;
   endfunction

   // classification of the three loaded vertices
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_mask[i] = ~dist_ff[i][DIST_W-1];
      end
      n_inside = 2'({1'b0, in_mask[0]} + {1'b0, in_mask[1]} + {1'b0, in_mask[2]});
      lead = 2'd0;
      if (n_inside == 2'd1) begin
         priority if (in_mask[0]) lead = 2'd0;
         else if (in_mask[1])     lead = 2'd1;
         else                     lead = 2'd2;
      end else if (n_inside == 2'd2) begin
         priority if (!in_mask[0]) lead = 2'd0;
         else if (!in_mask[1])     lead = 2'd1;
         else                      lead = 2'd2;
      end
   end

   assign far_idx  = {edge_sel_ff, ~edge_sel_ff};
   assign t_num    = dist_mag(dist_ff[0]);
   assign t_den    = t_num + dist_mag(dist_ff[far_idx]);
   assign off_term = {{(DIST_W - POS_W - N_FRAC){plane.offset[POS_W-1]}},
                      plane.offset, {N_FRAC{1'b0}}};
   assign out_load = !rsp_valid_ff || rsp_ready;
   assign item     = emit_item(mode_ff, emit_ff);
   assign sq_sum   = {1'b0, sq_r_ff} + {1'b0, sq_bit_ff};
   assign sq_ge    = {1'b0, sq_v_ff} >= sq_sum;
   assign nq       = div_rsp.quot[LEN_W-1:0];
   assign ncur     = cut_ff[edge_sel_ff].norm[op_c_ff[1:0]];
   assign last_op  = (op_c_ff == 3'd2);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (pop_valid) state_in = S_DIST;
         S_DIST:    if (op_v_ff == 2'd2 && last_op) state_in = S_DWAIT;
         S_DWAIT:   state_in = S_CLASS;
         S_CLASS: begin
            if (n_inside == 2'd0)       state_in = S_IDLE;
            else if (in_mask == 3'b111) state_in = S_EMIT;
            else                        state_in = S_TSTART;
         end
         S_TSTART:  state_in = S_TWAIT;
         S_TWAIT:   if (div_rsp.done) state_in = S_LERP;
         S_LERP:    if (op_c_ff == 3'd5) state_in = S_LWAIT;
         S_LWAIT: begin
            if (mode_ff == MODE_TWO) state_in = S_LEN;
            else                     state_in = edge_sel_ff ? S_EMIT : S_TSTART;
         end
         S_LEN:     if (last_op) state_in = S_LENWAIT;
         S_LENWAIT: state_in = S_SQRT;
         S_SQRT:    if (sq_bit_ff == LEN2_W'(1)) state_in = S_NSTART;
         S_NSTART: begin
            if (len_ff == '0) state_in = edge_sel_ff ? S_EMIT : S_TSTART;
            else              state_in = S_NWAIT;
         end
         S_NWAIT: begin
            if (div_rsp.done) begin
               if (last_op) state_in = edge_sel_ff ? S_EMIT : S_TSTART;
               else         state_in = S_NSTART;
            end
         end
         S_EMIT:    if (out_load && item.last) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      vtx_in       = vtx_ff;
      dist_in      = dist_ff;
      color_in     = color_ff;
      index_in     = index_ff;
      cut_in       = cut_ff;
      mode_in      = mode_ff;
      op_v_in      = op_v_ff;
      op_c_in      = op_c_ff;
      edge_sel_in  = edge_sel_ff;
      t_in         = t_ff;
      len2_in      = len2_ff;
      sq_v_in      = sq_v_ff;
      sq_r_in      = sq_r_ff;
      sq_bit_in    = sq_bit_ff;
      len_in       = len_ff;
      emit_in      = emit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      mul_a        = '0;
      mul_b        = '0;
      wb_in        = '0;
      div_req      = '0;
      pop_ready    = 1'b0;
      lerp_base    = '0;
      lerp_sum     = '0;
      src_v        = vtx_ff[0];

      // retire the product issued last cycle
      if (wb_ff.valid) begin
         unique case (wb_ff.kind)
            WB_DIST: begin
               dist_in[wb_ff.v] = ((wb_ff.c == 3'd0) ? off_term : dist_ff[wb_ff.v])
                                  + $signed(prod_ff[DIST_W-1:0]);
            end
            WB_LERP: begin
               if (wb_ff.c < 3'd3) begin
                  lerp_base = PROD_W'($signed(vtx_ff[0].pos[wb_ff.c[1:0]]));
                  lerp_sum  = lerp_base + (prod_ff >>> T_FRAC);
                  cut_in[edge_sel_ff].pos[wb_ff.c[1:0]] = lerp_sum[POS_W-1:0];
               end else begin
                  lerp_base = PROD_W'($signed(vtx_ff[0].norm[2'(wb_ff.c - 3'd3)]));
                  lerp_sum  = lerp_base + (prod_ff >>> T_FRAC);
                  cut_in[edge_sel_ff].norm[2'(wb_ff.c - 3'd3)] = lerp_sum[NORM_W-1:0];
               end
            end
            WB_LEN: begin
               len2_in = ((wb_ff.c == 3'd0) ? '0 : len2_ff) + prod_ff[LEN2_W-1:0];
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               vtx_in   = pop_data.vtx;
               color_in = pop_data.color;
               index_in = pop_data.tri_index;
               op_v_in  = 2'd0;
               op_c_in  = 3'd0;
            end
         end
         S_DIST: begin
            mul_a = MUL_A_W'($signed(vtx_ff[op_v_ff].pos[op_c_ff[1:0]]));
            mul_b = MUL_B_W'($signed(plane.norm[op_c_ff[1:0]]));
            wb_in = '{valid: 1'b1, kind: WB_DIST, v: op_v_ff, c: op_c_ff};
            if (last_op) begin
               op_c_in = 3'd0;
               op_v_in = op_v_ff + 2'd1;
            end else begin
               op_c_in = op_c_ff + 3'd1;
            end
         end
         S_DWAIT: ;
         S_CLASS: begin
            // rotate so the lead vertex comes first; winding is kept
            for (int i = 0; i < 3; i++) begin
               vtx_in[i]  = vtx_ff[rot_idx(lead, 2'(i))];
               dist_in[i] = dist_ff[rot_idx(lead, 2'(i))];
            end
            if (in_mask == 3'b111)     mode_in = MODE_ALL;
            else if (n_inside == 2'd1) mode_in = MODE_ONE;
            else                       mode_in = MODE_TWO;
            edge_sel_in = 1'b0;
            emit_in     = 3'd0;
         end
         S_TSTART: begin
            div_req = '{start: 1'b1, num: t_num, den: t_den, steps: STEP_W'(T_FRAC)};
         end
         S_TWAIT: begin
            if (div_rsp.done) begin
               t_in    = (t_den == '0) ? '0 : div_rsp.quot;
               op_c_in = 3'd0;
            end
         end
         S_LERP: begin
            if (op_c_ff < 3'd3) begin
               mul_a = MUL_A_W'($signed(vtx_ff[far_idx].pos[op_c_ff[1:0]]))
                     - MUL_A_W'($signed(vtx_ff[0].pos[op_c_ff[1:0]]));
            end else begin
               mul_a = MUL_A_W'($signed(vtx_ff[far_idx].norm[2'(op_c_ff - 3'd3)]))
                     - MUL_A_W'($signed(vtx_ff[0].norm[2'(op_c_ff - 3'd3)]));
            end
            mul_b   = $signed({1'b0, t_ff});
            wb_in   = '{valid: 1'b1, kind: WB_LERP, v: 2'd0, c: op_c_ff};
            op_c_in = op_c_ff + 3'd1;
         end
         S_LWAIT: begin
            op_c_in = 3'd0;
            if (mode_ff != MODE_TWO && !edge_sel_ff) edge_sel_in = 1'b1;
         end
         S_LEN: begin
            mul_a   = MUL_A_W'(norm_mag(ncur));
            mul_b   = MUL_B_W'(norm_mag(ncur));
            wb_in   = '{valid: 1'b1, kind: WB_LEN, v: 2'd0, c: op_c_ff};
            op_c_in = op_c_ff + 3'd1;
         end
         S_LENWAIT: begin
            sq_v_in   = len2_in;
            sq_r_in   = '0;
            sq_bit_in = SQ_BIT0;
            op_c_in   = 3'd0;
         end
         S_SQRT: begin
            // one bit pair of the integer square root per cycle
            if (sq_ge) begin
               sq_v_in = sq_v_ff - sq_sum[LEN2_W-1:0];
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff == LEN2_W'(1)) len_in = sq_r_in[LEN_W-1:0];
         end
         S_NSTART: begin
            if (len_ff == '0) begin
               if (!edge_sel_ff) edge_sel_in = 1'b1;
            end else begin
               div_req = '{start: 1'b1, num: DIV_W'(norm_mag(ncur)), den: DIV_W'(len_ff),
                           steps: STEP_W'(N_FRAC)};
            end
         end
         S_NWAIT: begin
            if (div_rsp.done) begin
               cut_in[edge_sel_ff].norm[op_c_ff[1:0]] =
                  ncur[NORM_W-1] ? NORM_W'(-nq) : NORM_W'(nq);
               op_c_in = op_c_ff + 3'd1;
               if (last_op && !edge_sel_ff) edge_sel_in = 1'b1;
            end
         end
         S_EMIT: begin
            unique case (item.src)
               SRC_V0:   src_v = vtx_ff[0];
               SRC_V1:   src_v = vtx_ff[1];
               SRC_V2:   src_v = vtx_ff[2];
               SRC_CUT0: src_v = cut_ff[0];
               default:  src_v = cut_ff[1];
            endcase
            if (out_load) begin
               rsp_valid_in         = 1'b1;
               rsp_in.out_x         = src_v.pos[0];
               rsp_in.out_y         = src_v.pos[1];
               rsp_in.out_z         = src_v.pos[2];
               rsp_in.out_nx        = src_v.norm[0];
               rsp_in.out_ny        = src_v.norm[1];
               rsp_in.out_nz        = src_v.norm[2];
               rsp_in.is_new_vertex = (item.src == SRC_CUT0) || (item.src == SRC_CUT1);
               rsp_in.out_vertex_id = rsp_in.is_new_vertex ? '0 : src_v.id;
               rsp_in.out_color     = color_ff;
               rsp_in.out_tri_index = index_ff;
               rsp_in.tri_end       = item.tri_end;
               rsp_in.run_last      = item.last;
               emit_in              = emit_ff + 3'd1;
            end
         end
         default: ;
      endcase
   end

   assign prod_in     = mul_a * mul_b;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wb_ff        <= wb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vtx_ff      <= vtx_in;
      dist_ff     <= dist_in;
      color_ff    <= color_in;
      index_ff    <= index_in;
      cut_ff      <= cut_in;
      mode_ff     <= mode_in;
      op_v_ff     <= op_v_in;
      op_c_ff     <= op_c_in;
      edge_sel_ff <= edge_sel_in;
      t_ff        <= t_in;
      len2_ff     <= len2_in;
      sq_v_ff     <= sq_v_in;
      sq_r_ff     <= sq_r_in;
      sq_bit_ff   <= sq_bit_in;
      len_ff      <= len_in;
      emit_ff     <= emit_in;
      prod_ff     <= prod_in;
      rsp_ff      <= rsp_in;
   end

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_TWAIT || state_ff == S_NWAIT))
      else $error("divider finished outside a wait state");

   a_last_ends_tri: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.run_last) |-> rsp_ff.tri_end)
      else $error("last result does not close a triangle");

   a_new_vertex_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_new_vertex) |-> (rsp_ff.out_vertex_id == '0))
      else $error("cut vertex carries a vertex id");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> (state_ff == S_DIST))
      else $error("popped triangle not processed");

endmodule

[hdl/triangle_plane_clipper.sv]
// Top level of the triangle plane clipper: register file and unit wiring.
// Depends on tpc_pkg, tpc_front, tpc_queue, tpc_div and tpc_back.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    req_payload (tpc_pkg::req_type), one vertex
//   rsp      out        rsp_valid/ready    rsp_payload (tpc_pkg::rsp_type), one vertex
//   csr      in         psel/penable/...   four plane registers, 32-bit words
//
// Vertex transactions are taken one per cycle, except while a third one waits on a
// full queue; every third one closes a triangle and enters a two-deep queue. The
// clip engine takes longer on a triangle with one vertex inside than on one that
// passes or is dropped, and longer still with two inside (less when a cut normal
// has zero length); the shared multiplier and the one-bit-per-cycle divider and
// square root set its pace. Reset clears control state and sets the plane to
// normal (0, 0, 1.0) with zero offset; held vertices are written before use.
// Stalls on rsp hold the engine; the queue lets the front end keep collecting triangles meanwhile.
module triangle_plane_clipper (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tpc_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tpc_pkg::rsp_type             rsp_payload,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tpc_pkg::CSR_AW-1:0]   paddr,
   input  logic [tpc_pkg::CSR_DW-1:0]   pwdata,
   output logic [tpc_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);
   import tpc_pkg::*;

   plane_type     plane_ff, plane_in;
   csr_index_type csr_idx;
   logic          csr_write;

   logic          push_valid, push_ready;
   tri_type       push_data;
   logic          pop_valid, pop_ready;
   tri_type       pop_data;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   // register file: always ready, write on the access phase
   assign pready    = 1'b1;
   assign csr_idx   = csr_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      plane_in = plane_ff;
      if (csr_write) begin
         unique case (csr_idx)
            CSR_PNX:  plane_in.norm[0] = pwdata[NORM_W-1:0];
            CSR_PNY:  plane_in.norm[1] = pwdata[NORM_W-1:0];
            CSR_PNZ:  plane_in.norm[2] = pwdata[NORM_W-1:0];
            default:  plane_in.offset  = pwdata[POS_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_PNX:  prdata = CSR_DW'(plane_ff.norm[0]);
         CSR_PNY:  prdata = CSR_DW'(plane_ff.norm[1]);
         CSR_PNZ:  prdata = CSR_DW'(plane_ff.norm[2]);
         default:  prdata = CSR_DW'(plane_ff.offset);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff.norm[0] <= '0;
         plane_ff.norm[1] <= '0;
         plane_ff.norm[2] <= PNZ_RESET;
         plane_ff.offset  <= '0;
      end else begin
         plane_ff <= plane_in;
      end
   end

   // gather three vertices into a triangle record
   tpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // decouple collection from clipping
   tpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // shared divider for edge parameters and normal scaling
   tpc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // clip each triangle and drive the result register
   tpc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .plane       (plane_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
